### rtl/ipv4dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Types and constants shared by the dotted-quad address parser modules.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 32;
   localparam int ACCUM_W  = 9;
   localparam int WIDE_W   = 12;
   localparam int COUNT_W  = 3;
   localparam int BUDGET_W = 6;
   localparam int OCTETS   = 4;
   localparam int RSP_W    = 40;

   localparam logic [CHAR_W-1:0]   CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0]   CHAR_DOT   = 8'h2e;
   localparam logic [CHAR_W-1:0]   CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]   CHAR_NINE  = 8'h39;
   localparam logic [ACCUM_W-1:0]  OCTET_MAX  = 9'd255;
   localparam logic [ACCUM_W-1:0]  OCTET_SAT  = 9'd256;
   localparam logic [COUNT_W-1:0]  OCTETS_NEEDED = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD      = 2'd1,
      ST_NONDIGIT = 2'd2
   } status_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [ADDR_W-1:0] address;
   } result_type;

endpackage

### rtl/ipv4dq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_core
// Parser state and the per-character update: octet accumulator, octet count,
// digit/dot budget, packed address and skip-to-terminator flag.
// ----------------------------------------------------------------------------
module ipv4dq_core
   import ipv4dq_pkg::*;
#(
   parameter int CHAR_BUDGET = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat_in,
   input  logic [CHAR_W-1:0] char_in,
   output result_type        result
);

   localparam logic [BUDGET_W-1:0] BUDGET_INIT = BUDGET_W'(CHAR_BUDGET);

   logic [COUNT_W-1:0]  count_ff,  count_in;
   logic [ACCUM_W-1:0]  accum_ff,  accum_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [ADDR_W-1:0]   packed_ff, packed_in;
   logic                skip_ff,   skip_in;

   logic                is_nul, is_dot, is_digit, budget_ok;
   logic [WIDE_W-1:0]   wide_sum;
   logic [ADDR_W-1:0]   packed_new;
   logic [COUNT_W-1:0]  count_new;
   logic                finish;

   always_comb begin
      is_nul    = (char_in == CHAR_NUL);
      is_dot    = (char_in == CHAR_DOT);
      is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
      budget_ok = (budget_ff > BUDGET_W'(1));
      wide_sum  = (WIDE_W'(accum_ff) << 3) + (WIDE_W'(accum_ff) << 1)
                + WIDE_W'(char_in - CHAR_ZERO);
      count_new = count_ff + COUNT_W'(1);
      packed_new = packed_ff;
      for (int i = 0; i < OCTETS; i++) begin
         if (count_ff[1:0] == 2'(i)) begin
            packed_new[8*i +: 8] = packed_ff[8*i +: 8] | accum_ff[7:0];
         end
      end

      count_in       = count_ff;
      accum_in       = accum_ff;
      budget_in      = budget_ff;
      packed_in      = packed_ff;
      skip_in        = skip_ff;
      finish         = 1'b0;
      result.valid   = 1'b0;
      result.status  = ST_OK;
      result.address = '0;

      if (skip_ff) begin
         if (is_nul) begin
            skip_in = 1'b0;
         end
      end else if (!is_dot && !is_nul) begin
         if (!is_digit) begin
            finish        = 1'b1;
            result.status = ST_NONDIGIT;
         end else if (!budget_ok) begin
            finish        = 1'b1;
            result.status = ST_BAD;
         end else begin
            budget_in = budget_ff - BUDGET_W'(1);
            accum_in  = (wide_sum > WIDE_W'(OCTET_SAT)) ? OCTET_SAT : wide_sum[ACCUM_W-1:0];
         end
      end else if (accum_ff > OCTET_MAX) begin
         finish        = 1'b1;
         result.status = ST_BAD;
      end else if (is_nul) begin
         finish = 1'b1;
         if (count_new != OCTETS_NEEDED) begin
            result.status = ST_BAD;
         end else begin
            result.address = packed_new;
         end
      end else if (!budget_ok) begin
         finish        = 1'b1;
         result.status = ST_BAD;
      end else if (count_new >= OCTETS_NEEDED) begin
         finish         = 1'b1;
         result.address = packed_new;
      end else begin
         count_in  = count_new;
         accum_in  = '0;
         budget_in = budget_ff - BUDGET_W'(1);
         packed_in = packed_new;
      end

      if (finish) begin
         result.valid = 1'b1;
         count_in     = '0;
         accum_in     = '0;
         budget_in    = BUDGET_INIT;
         packed_in    = '0;
         skip_in      = !is_nul;
      end
      result.valid = result.valid && beat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         accum_ff  <= '0;
         budget_ff <= BUDGET_INIT;
         packed_ff <= '0;
         skip_ff   <= 1'b0;
      end else if (beat_in) begin
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         budget_ff <= budget_in;
         packed_ff <= packed_in;
         skip_ff   <= skip_in;
      end
   end

   a_count_open: assert property (@(posedge clock) disable iff (reset)
      count_ff < OCTETS_NEEDED)
      else $error("octet count reached four without a result");

   a_accum_sat: assert property (@(posedge clock) disable iff (reset)
      accum_ff <= OCTET_SAT)
      else $error("octet accumulator above saturation value");

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (count_ff == '0) && (accum_ff == '0) && (packed_ff == '0))
      else $error("parser state not cleared while skipping");

endmodule

### rtl/ipv4_dotted_quad_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Parses a NUL-terminated dotted-decimal IPv4 string, one character per beat,
// into a packed 32-bit address with a status code.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while req_tready is high; each beat
// updates the parser state registers. A string gives exactly one result beat:
// an error at the first fault, or success once the fourth octet closes. The
// result is registered, in the skid register if the result register is full.
// A two-entry output buffer (result register plus skid register) lets input
// continue while a result waits; req_tready drops only when both entries are
// full. After a result, characters up to and including the NUL are dropped.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser
   import ipv4dq_pkg::*;
#(
   parameter int CHAR_BUDGET = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] char_in
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [1:0] status, [33:2] address
);

   result_type step_result;
   logic       beat;
   logic       pop;

   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic              skid_valid_ff, skid_valid_in;
   status_type        skid_status_ff, skid_status_in;
   logic [ADDR_W-1:0] skid_addr_ff, skid_addr_in;

   assign req_tready = !skid_valid_ff;
   assign beat       = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   ipv4dq_core #(
      .CHAR_BUDGET (CHAR_BUDGET)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .beat_in (beat),
      .char_in (req_tdata),
      .result  (step_result)
   );

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_addr_in    = out_addr_ff;
      skid_valid_in  = skid_valid_ff;
      skid_status_in = skid_status_ff;
      skid_addr_in   = skid_addr_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in   = 1'b1;
            out_status_in  = skid_status_ff;
            out_addr_in    = skid_addr_ff;
            skid_valid_in  = step_result.valid;
            skid_status_in = step_result.status;
            skid_addr_in   = step_result.address;
         end else begin
            out_valid_in  = step_result.valid;
            out_status_in = step_result.status;
            out_addr_in   = step_result.address;
         end
      end else if (step_result.valid) begin
         skid_valid_in  = 1'b1;
         skid_status_in = step_result.status;
         skid_addr_in   = step_result.address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_status_ff  <= out_status_in;
      out_addr_ff    <= out_addr_in;
      skid_status_ff <= skid_status_in;
      skid_addr_ff   <= skid_addr_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - ADDR_W - STATUS_W){1'b0}}, out_addr_ff, out_status_ff};

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty result register");

   a_error_zero_addr: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff != ST_OK) |-> out_addr_ff == '0)
      else $error("error result carries a nonzero address");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      step_result.valid |-> !skid_valid_ff)
      else $error("result produced with no buffer space");

   a_result_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && out_addr_ff == $past(skid_addr_ff))
      else $error("skid entry not advanced to result register");

endmodule
